@@ design/dmma_pkg.sv @@
// package for the dense matrix multiply-accumulate block
// sizes, opcodes, controller states and the word structs shared by all modules
// depends on nothing
`default_nettype none

package dmma_pkg;

    localparam int MAX_DIM = 8;
    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int AADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int DRAIN_N = MAX_DIM + 3;
    localparam int DRN_W   = $clog2(DRAIN_N + 1);

    localparam logic [CIDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DEPTH = 2'd2;

    typedef enum logic [2:0] {
        OP_WR_A  = 3'd0,
        OP_WR_B  = 3'd1,
        OP_CLEAR = 3'd2,
        OP_ACC   = 3'd3,
        OP_RD_C  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [ELEM_W-1:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_value;
        logic                    saturated;
    } t_out_word;

    // one A element travelling down the row of cells
    typedef struct packed {
        logic                     valid;
        logic signed [ELEM_W-1:0] a;
        logic [IDX_W-1:0]         i;
        logic [IDX_W-1:0]         k;
    } t_mac_beat;

endpackage

`default_nettype wire

@@ design/dmma_cell.sv @@
// one column cell: holds a column of B and a column of C with sticky flags
// multiplies the passing A element by its B entry and accumulates; uses dmma_pkg
`default_nettype none

module dmma_cell (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  dmma_pkg::t_mac_beat                i_beat,
    output dmma_pkg::t_mac_beat                o_beat,
    input  wire                                i_active,
    input  wire                                i_b_we,
    input  wire [dmma_pkg::IDX_W-1:0]          i_b_row,
    input  wire [dmma_pkg::ELEM_W-1:0]         i_b_val,
    input  wire                                i_clear,
    input  wire [dmma_pkg::IDX_W-1:0]          i_rd_row,
    output dmma_pkg::t_out_word                o_rd
);

    logic [dmma_pkg::ELEM_W-1:0]        r_b   [dmma_pkg::MAX_DIM];
    logic signed [dmma_pkg::ACC_W-1:0]  r_c   [dmma_pkg::MAX_DIM];
    logic                               r_sat [dmma_pkg::MAX_DIM];
    dmma_pkg::t_mac_beat                r_pass;
    logic                               r_pv;
    logic [dmma_pkg::IDX_W-1:0]         r_pi;
    logic signed [dmma_pkg::PROD_W-1:0] r_prod;

    logic signed [dmma_pkg::PROD_W-1:0] n_prod;
    logic [dmma_pkg::IDX_W-1:0]         w_addr;
    logic signed [dmma_pkg::ACC_W-1:0]  w_c;
    logic                               w_s;
    logic signed [dmma_pkg::ACC_W:0]    w_sum;
    logic signed [dmma_pkg::ACC_W-1:0]  n_c;
    logic                               w_ovf;

    assign n_prod = $signed(i_beat.a) * $signed(r_b[i_beat.k]);

    // single read port: the accumulate row while a product waits, else the read row
    assign w_addr = r_pv ? r_pi : i_rd_row;
    assign w_c    = r_c[w_addr];
    assign w_s    = r_sat[w_addr];

    assign w_sum = {w_c[dmma_pkg::ACC_W-1], w_c}
                 + {{(dmma_pkg::ACC_W + 1 - dmma_pkg::PROD_W){r_prod[dmma_pkg::PROD_W-1]}},
                    r_prod};
    assign w_ovf = w_sum[dmma_pkg::ACC_W] != w_sum[dmma_pkg::ACC_W-1];

    always_comb begin
        if (!w_ovf) begin
            n_c = w_sum[dmma_pkg::ACC_W-1:0];
        end else if (w_sum[dmma_pkg::ACC_W]) begin
            n_c = {1'b1, {(dmma_pkg::ACC_W-1){1'b0}}};
        end else begin
            n_c = {1'b0, {(dmma_pkg::ACC_W-1){1'b1}}};
        end
    end

    assign o_beat          = r_pass;
    assign o_rd.sum_value  = w_c;
    assign o_rd.saturated  = w_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass.valid <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_pass.valid <= i_beat.valid;
            r_pv         <= i_beat.valid && i_active;
        end
        r_pass.a <= i_beat.a;
        r_pass.i <= i_beat.i;
        r_pass.k <= i_beat.k;
        r_pi     <= i_beat.i;
        r_prod   <= n_prod;
        if (i_b_we) begin
            r_b[i_b_row] <= i_b_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int e = 0; e < dmma_pkg::MAX_DIM; e++) begin
                r_c[e]   <= '0;
                r_sat[e] <= 1'b0;
            end
        end else if (r_pv) begin
            r_c[r_pi]   <= n_c;
            r_sat[r_pi] <= w_s | w_ovf;
        end
    end

endmodule

`default_nettype wire

@@ design/dense_matrix_multiply_accumulate.sv @@
// top level: word handshakes, size registers, A memory, sequencer, row of column cells
// depends on dmma_pkg and dmma_cell
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_valid / o_ready         | i_in_word  (t_in_word)
//  out     | output    | o_valid / i_ready         | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a read result sits in an output register
// accumulate issues rows*depth A elements (one A element per cycle from the A memory),
//   then waits for the last element to ripple down the cells, no input meanwhile
// reset clears C and the sticky flags and sets the size registers to MAX_DIM
// a waiting result stalls new words only if it is not taken in the same cycle
`default_nettype none

module dense_matrix_multiply_accumulate (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  dmma_pkg::t_in_word               i_in_word,
    output logic                             o_valid,
    input  wire                              i_ready,
    output dmma_pkg::t_out_word              o_out_word,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [dmma_pkg::CIDX_W-1:0]       i_cfg_index,
    input  wire [dmma_pkg::CFG_W-1:0]        i_cfg_data
);

    dmma_pkg::t_state                 r_state, n_state;
    logic [dmma_pkg::DIM_W-1:0]       r_rows, r_cols, r_depth, w_cfg_clamped;
    logic [dmma_pkg::IDX_W-1:0]       r_si, r_sk;
    logic [dmma_pkg::DRN_W-1:0]       r_drain;
    logic                             r_iss_v;
    logic [dmma_pkg::IDX_W-1:0]       r_iss_i, r_iss_k;
    logic [dmma_pkg::ELEM_W-1:0]      r_a_rd;
    logic [dmma_pkg::ELEM_W-1:0]      a_mem [dmma_pkg::MAX_DIM * dmma_pkg::MAX_DIM];
    logic                             r_out_v;
    dmma_pkg::t_out_word              r_out;

    logic                             w_acc, w_issue, w_last;
    logic                             w_a_ok, w_b_ok, w_rd_ok;
    logic [dmma_pkg::AADDR_W-1:0]     w_a_waddr, w_a_raddr;
    dmma_pkg::t_mac_beat              w_beat [dmma_pkg::MAX_DIM + 1];
    dmma_pkg::t_out_word              w_rd   [dmma_pkg::MAX_DIM];

    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && o_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_clamped = dmma_pkg::DIM_W'(1);
        end else if (dmma_pkg::DIM_W'(i_cfg_data) > dmma_pkg::DIM_W'(dmma_pkg::MAX_DIM)) begin
            w_cfg_clamped = dmma_pkg::DIM_W'(dmma_pkg::MAX_DIM);
        end else begin
            w_cfg_clamped = dmma_pkg::DIM_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= dmma_pkg::DIM_W'(dmma_pkg::MAX_DIM);
            r_cols  <= dmma_pkg::DIM_W'(dmma_pkg::MAX_DIM);
            r_depth <= dmma_pkg::DIM_W'(dmma_pkg::MAX_DIM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dmma_pkg::CFG_ROWS:  r_rows  <= w_cfg_clamped;
                dmma_pkg::CFG_COLS:  r_cols  <= w_cfg_clamped;
                dmma_pkg::CFG_DEPTH: r_depth <= w_cfg_clamped;
                default: ;
            endcase
        end
    end

    assign w_a_ok  = (dmma_pkg::DIM_W'(i_in_word.row_index) < r_rows)
                  && (dmma_pkg::DIM_W'(i_in_word.col_index) < r_depth);
    assign w_b_ok  = (dmma_pkg::DIM_W'(i_in_word.row_index) < r_depth)
                  && (dmma_pkg::DIM_W'(i_in_word.col_index) < r_cols);
    assign w_rd_ok = (dmma_pkg::DIM_W'(i_in_word.row_index) < r_rows)
                  && (dmma_pkg::DIM_W'(i_in_word.col_index) < r_cols);

    assign w_a_waddr = dmma_pkg::AADDR_W'(i_in_word.row_index)
                     * dmma_pkg::AADDR_W'(dmma_pkg::MAX_DIM)
                     + dmma_pkg::AADDR_W'(i_in_word.col_index);
    assign w_a_raddr = dmma_pkg::AADDR_W'(r_si) * dmma_pkg::AADDR_W'(dmma_pkg::MAX_DIM)
                     + dmma_pkg::AADDR_W'(r_sk);

    assign w_last = (dmma_pkg::DIM_W'(r_si) == r_rows - dmma_pkg::DIM_W'(1))
                 && (dmma_pkg::DIM_W'(r_sk) == r_depth - dmma_pkg::DIM_W'(1));

    // controller next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmma_pkg::S_IDLE: begin
                if (w_acc && i_in_word.opcode == dmma_pkg::OP_ACC) begin
                    n_state = dmma_pkg::S_RUN;
                end
            end
            dmma_pkg::S_RUN: begin
                if (w_last) begin
                    n_state = dmma_pkg::S_DRAIN;
                end
            end
            dmma_pkg::S_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = dmma_pkg::S_IDLE;
                end
            end
            default: n_state = dmma_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        o_ready = 1'b0;
        w_issue = 1'b0;
        unique case (r_state)
            dmma_pkg::S_IDLE:  o_ready = !r_out_v || i_ready;
            dmma_pkg::S_RUN:   w_issue = 1'b1;
            dmma_pkg::S_DRAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmma_pkg::S_IDLE;
            r_iss_v <= 1'b0;
            r_si    <= '0;
            r_sk    <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_iss_v <= w_issue;
            if (r_state == dmma_pkg::S_IDLE) begin
                r_si <= '0;
                r_sk <= '0;
            end else if (w_issue) begin
                if (dmma_pkg::DIM_W'(r_sk) == r_depth - dmma_pkg::DIM_W'(1)) begin
                    r_sk <= '0;
                    r_si <= r_si + dmma_pkg::IDX_W'(1);
                end else begin
                    r_sk <= r_sk + dmma_pkg::IDX_W'(1);
                end
            end
            if (w_issue && w_last) begin
                r_drain <= dmma_pkg::DRN_W'(dmma_pkg::DRAIN_N);
            end else if (r_drain != '0) begin
                r_drain <= r_drain - dmma_pkg::DRN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in_word.opcode == dmma_pkg::OP_WR_A && w_a_ok) begin
            a_mem[w_a_waddr] <= i_in_word.element_value;
        end
        r_a_rd  <= a_mem[w_a_raddr];
        r_iss_i <= r_si;
        r_iss_k <= r_sk;
    end

    assign w_beat[0].valid = r_iss_v;
    assign w_beat[0].a     = r_a_rd;
    assign w_beat[0].i     = r_iss_i;
    assign w_beat[0].k     = r_iss_k;

    for (genvar j = 0; j < dmma_pkg::MAX_DIM; j++) begin : g_cell
        dmma_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_beat   (w_beat[j]),
            .o_beat   (w_beat[j+1]),
            .i_active (dmma_pkg::DIM_W'(j) < r_cols),
            .i_b_we   (w_acc && i_in_word.opcode == dmma_pkg::OP_WR_B && w_b_ok
                       && i_in_word.col_index == dmma_pkg::IDX_W'(j)),
            .i_b_row  (i_in_word.row_index),
            .i_b_val  (i_in_word.element_value),
            .i_clear  (w_acc && i_in_word.opcode == dmma_pkg::OP_CLEAR),
            .i_rd_row (i_in_word.row_index),
            .o_rd     (w_rd[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_acc && i_in_word.opcode == dmma_pkg::OP_RD_C) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
        if (w_acc && i_in_word.opcode == dmma_pkg::OP_RD_C) begin
            r_out <= w_rd_ok ? w_rd[i_in_word.col_index] : '0;
        end
    end

    assign o_valid    = r_out_v;
    assign o_out_word = r_out;

    // the last cell has finished before the controller takes a new word
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dmma_pkg::S_IDLE |-> !w_beat[dmma_pkg::MAX_DIM].valid)
        else $error("element still in the cell row while idle");

    a_run_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dmma_pkg::S_RUN |-> dmma_pkg::DIM_W'(r_si) < r_rows)
        else $error("row counter past configured rows");

    a_acc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in_word.opcode == dmma_pkg::OP_ACC |=> r_state == dmma_pkg::S_RUN)
        else $error("accumulate word did not start the sequencer");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != dmma_pkg::S_IDLE |-> !o_ready)
        else $error("input accepted during accumulate");

endmodule

`default_nettype wire

@@ tb/sv/dmma_checker.sv @@
// checker for the dense matrix multiply-accumulate block
// watches the in, out and cfg channels, predicts every read word and compares it
// depends on dmma_pkg
`default_nettype none

module dmma_checker
    import dmma_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire                 i_ready_in,
    input  t_in_word            i_in_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  t_out_word           i_out_word,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [CIDX_W-1:0]    i_cfg_index,
    input  wire [CFG_W-1:0]     i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    localparam longint SUM_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic signed [ACC_W-1:0]  c_mem [MAX_DIM*MAX_DIM];
    logic                     c_sat [MAX_DIM*MAX_DIM];
    int                       n_rows, n_cols, n_depth;
    t_out_word                expected_reads [$];
    int                       mismatches;

    assign o_errors  = mismatches;
    assign o_pending = expected_reads.size();

    function automatic int clamp_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    task automatic clear_sums();
        for (int n = 0; n < MAX_DIM*MAX_DIM; n++) begin
            c_mem[n] = '0;
            c_sat[n] = 1'b0;
        end
    endtask

    // i over rows, k over depth, j over columns: each element sums k ascending
    task automatic run_mac();
        longint prod, sum;
        int ci;
        for (int i = 0; i < n_rows; i++)
            for (int k = 0; k < n_depth; k++)
                for (int j = 0; j < n_cols; j++) begin
                    ci   = i*MAX_DIM + j;
                    prod = longint'(a_mem[i*MAX_DIM+k]) * longint'(b_mem[k*MAX_DIM+j]);
                    sum  = longint'(c_mem[ci]) + prod;
                    if (sum > SUM_HI) begin
                        sum = SUM_HI;
                        c_sat[ci] = 1'b1;
                    end else if (sum < SUM_LO) begin
                        sum = SUM_LO;
                        c_sat[ci] = 1'b1;
                    end
                    c_mem[ci] = sum[ACC_W-1:0];
                end
    endtask

    task automatic model_step(t_in_word w);
        t_out_word r;
        int row, col;
        row = int'(w.row_index);
        col = int'(w.col_index);
        case (w.opcode)
            OP_WR_A: begin
                if (row < n_rows && col < n_depth) a_mem[row*MAX_DIM+col] = w.element_value;
            end
            OP_WR_B: begin
                if (row < n_depth && col < n_cols) b_mem[row*MAX_DIM+col] = w.element_value;
            end
            OP_CLEAR: clear_sums();
            OP_ACC:   run_mac();
            OP_RD_C: begin
                r = '0;
                if (row < n_rows && col < n_cols) begin
                    r.sum_value = c_mem[row*MAX_DIM+col];
                    r.saturated = c_sat[row*MAX_DIM+col];
                end
                expected_reads.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            clear_sums();
            n_rows  = MAX_DIM;
            n_cols  = MAX_DIM;
            n_depth = MAX_DIM;
            expected_reads.delete();
            mismatches <= 0;
        end else begin
            // result first: a read accepted now cannot be answered in the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_reads.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: sum %0d sat %0b",
                                 i_out_word.sum_value, i_out_word.saturated);
                    mismatches <= mismatches + 1;
                end else begin
                    e = expected_reads.pop_front();
                    if (e.sum_value !== i_out_word.sum_value ||
                        e.saturated !== i_out_word.saturated) begin
                        if (mismatches < 10)
                            $display("read mismatch: expected sum %0d sat %0b, got sum %0d sat %0b",
                                     e.sum_value, e.saturated,
                                     i_out_word.sum_value, i_out_word.saturated);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) model_step(i_in_word);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:  n_rows  = clamp_size(i_cfg_data);
                    CFG_COLS:  n_cols  = clamp_size(i_cfg_data);
                    CFG_DEPTH: n_depth = clamp_size(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench top for the dense matrix multiply-accumulate block
// drives the in, cfg and out channels and gives the verdict; depends on dmma_pkg,
// dmma_checker and the block itself
`default_nettype none

module tb_top;
    import dmma_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_in_word            i_in_word = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_out_word           o_out_word;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    int                  errors, pending;
    int                  burst_left = 0;
    bit                  hold_go = 1'b0;
    int                  sz_rows, sz_cols, sz_depth;

    always #5 i_clk = ~i_clk;

    dense_matrix_multiply_accumulate uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_in_word(i_in_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    dmma_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_in_word(i_in_word),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: stall rate drawn anew at random, one long hold-off on request
    initial begin
        int tick, rate;
        tick = 0;
        rate = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: rate = 0;
                    1: rate = 25;
                    2: rate = 60;
                    default: rate = 90;
                endcase
            end
            tick++;
            i_ready <= ($urandom_range(0, 99) >= rate);
        end
    end

    function automatic t_in_word mk(t_op op, int row, int col, int val);
        t_in_word w;
        w.opcode        = op;
        w.row_index     = row[IDX_W-1:0];
        w.col_index     = col[IDX_W-1:0];
        w.element_value = val[ELEM_W-1:0];
        return w;
    endfunction

    // hold the word until it is taken, valid stays up for the next word
    task automatic put(t_in_word w);
        i_valid   <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send(t_in_word w);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        put(w);
    endtask

    // block idle: all reads back, then room for an accumulate still running
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (MAX_DIM*MAX_DIM + MAX_DIM + 20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(int r, int c, int d);
        cfg_write(CFG_ROWS, r[CFG_W-1:0]);
        cfg_write(CFG_COLS, c[CFG_W-1:0]);
        cfg_write(CFG_DEPTH, d[CFG_W-1:0]);
        sz_rows  = (r == 0) ? 1 : (r > MAX_DIM) ? MAX_DIM : r;
        sz_cols  = (c == 0) ? 1 : (c > MAX_DIM) ? MAX_DIM : c;
        sz_depth = (d == 0) ? 1 : (d > MAX_DIM) ? MAX_DIM : d;
    endtask

    function automatic int rand_elem();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick(int lim);
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, lim - 1);
        return $urandom_range(0, MAX_DIM - 1);
    endfunction

    function automatic t_in_word rand_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return mk(OP_WR_A, pick(sz_rows), pick(sz_depth), rand_elem());
        if (p < 60) return mk(OP_WR_B, pick(sz_depth), pick(sz_cols), rand_elem());
        if (p < 88) return mk(OP_RD_C, pick(sz_rows), pick(sz_cols), rand_elem());
        if (p < 94) return mk(OP_ACC, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
        if (p < 97) return mk(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7), 0);
        return t_in_word'({3'($urandom_range(5, 7)), 22'($urandom)});
    endfunction

    initial begin
        t_in_word w;
        sz_rows  = MAX_DIM;
        sz_cols  = MAX_DIM;
        sz_depth = MAX_DIM;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every A and B entry gets written once at full size
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++) begin
                send(mk(OP_WR_A, r, c, rand_elem()));
                send(mk(OP_WR_B, r, c, rand_elem()));
            end

        // directed: extremes, every opcode, ignored writes, reads outside sizes
        send(mk(OP_RD_C, 0, 0, 0));
        send(mk(OP_ACC, 0, 0, 0));
        send(mk(OP_RD_C, 0, 0, 0));
        send(mk(OP_RD_C, 7, 7, -1));
        send(mk(OP_ACC, 7, 7, 0));
        send(mk(OP_RD_C, 3, 5, 0));
        send(t_in_word'({3'd5, 22'h3fffff}));
        send(t_in_word'({3'd6, 22'h0}));
        send(t_in_word'({3'd7, 22'h155555}));
        send(mk(OP_CLEAR, 7, 7, -1));
        send(mk(OP_RD_C, 7, 7, 0));
        settle();
        set_sizes(3, 2, 5);
        cfg_write(2'd3, 4'hf);
        send(mk(OP_WR_A, 3, 0, 32767));
        send(mk(OP_WR_A, 0, 5, -32768));
        send(mk(OP_WR_B, 0, 2, 32767));
        send(mk(OP_WR_B, 5, 0, -32768));
        send(mk(OP_ACC, 0, 0, 0));
        send(mk(OP_RD_C, 2, 1, 0));
        send(mk(OP_RD_C, 5, 1, 0));
        send(mk(OP_RD_C, 0, 2, 0));
        settle();
        set_sizes(0, 15, 9);
        send(mk(OP_ACC, 0, 0, 0));
        send(mk(OP_RD_C, 0, 7, 0));
        send(mk(OP_RD_C, 1, 0, 0));
        settle();

        // largest products: C00 climbs toward the top bound, C01 toward the bottom one
        set_sizes(1, 2, 8);
        send(mk(OP_CLEAR, 0, 0, 0));
        for (int k = 0; k < MAX_DIM; k++) begin
            send(mk(OP_WR_A, 0, k, -32768));
            send(mk(OP_WR_B, k, 0, -32768));
            send(mk(OP_WR_B, k, 1, 32767));
        end
        for (int n = 0; n < 20; n++) begin
            put(mk(OP_ACC, 0, 0, 0));
            if (n % 8 == 0) put(mk(OP_RD_C, 0, 1, 0));
        end
        send(mk(OP_RD_C, 0, 0, 0));
        send(mk(OP_RD_C, 0, 1, 0));
        send(mk(OP_ACC, 0, 0, 0));
        send(mk(OP_RD_C, 0, 0, 0));
        send(mk(OP_RD_C, 0, 1, 0));
        send(mk(OP_CLEAR, 0, 0, 0));
        send(mk(OP_RD_C, 0, 0, 0));
        settle();

        // random phases over random and extreme sizes
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: set_sizes(8, 8, 8);
                1: set_sizes(1, 1, 1);
                2: set_sizes(0, 15, 0);
                default: set_sizes($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 15));
            endcase
            if (ph == 3) hold_go = 1'b1;
            for (int n = 0; n < 88; n++) begin
                w = rand_word();
                send(w);
            end
            settle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
